### rtl/prlxf_pkg.sv
// Shared constants, types and helpers for the preamble/length/XOR frame receiver.
package prlxf_pkg;

    // Width of the frame position counter
    localparam int COUNT_BITS_DEFAULT = 16;

    // Capacity register reset value
    localparam logic [15:0] MAX_FRAME_RESET = 16'd512;

    // Receive phases
    localparam logic [1:0] PH_PREAMBLE = 2'd0;
    localparam logic [1:0] PH_LENGTH   = 2'd1;
    localparam logic [1:0] PH_BODY     = 2'd2;
    localparam logic [1:0] PH_DONE     = 2'd3;

    // Error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_OVERFLOW = 3'd1;
    localparam logic [2:0] ERR_PREAMBLE = 3'd2;
    localparam logic [2:0] ERR_LENGTH   = 3'd3;
    localparam logic [2:0] ERR_CHECKSUM = 3'd4;

    // Opcodes
    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // Frame layout
    localparam int PREAMBLE_LEN = 5;
    localparam int HEADER_LEN   = 7;

    // One result beat
    typedef struct packed {
        logic [7:0]  data_byte;
        logic [15:0] byte_index;
        logic [1:0]  rx_phase;
        logic [2:0]  error_code;
        logic        frame_done;
    } result_t;

    // Expected preamble byte at a given offset
    function automatic logic [7:0] sync_byte(input logic [2:0] pos);
        logic [7:0] val;
        unique case (pos)
            3'd0, 3'd1, 3'd2: val = 8'hAA;
            3'd3:             val = 8'h96;
            3'd4:             val = 8'h69;
            default:          val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

### rtl/prlxf_core.sv
// Frame state registers and the single-pass per-byte decode logic.
module prlxf_core #(
    parameter int COUNT_BITS = prlxf_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic                opcode,
    input  logic [7:0]          rx_byte,
    input  logic [15:0]         max_frame_bytes,
    output prlxf_pkg::result_t  result
);

    localparam logic [16:0] CountCap = 17'((17'd1 << COUNT_BITS) - 17'd1);

    logic [1:0]            phase_reg, phase_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [15:0]           flen_reg, flen_next;
    logic [7:0]            xor_reg, xor_next;
    logic                  pmatch_reg, pmatch_next;

    // Working copies after the implicit clear that follows a finished frame
    logic [1:0]            ph_cur;
    logic [COUNT_BITS-1:0] cnt_cur;
    logic [15:0]           flen_cur;
    logic [7:0]            xor_cur;
    logic                  pm_cur;

    logic [15:0]           cap;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [16:0]           body_end;
    logic [15:0]           flen_new;
    logic                  pm_new;
    logic [2:0]            err;
    logic                  done;
    logic [1:0]            ph_new;

    always_comb
    begin
        if (phase_reg == prlxf_pkg::PH_DONE)
        begin
            ph_cur   = prlxf_pkg::PH_PREAMBLE;
            cnt_cur  = '0;
            flen_cur = '0;
            xor_cur  = '0;
            pm_cur   = 1'b1;
        end
        else
        begin
            ph_cur   = phase_reg;
            cnt_cur  = count_reg;
            flen_cur = flen_reg;
            xor_cur  = xor_reg;
            pm_cur   = pmatch_reg;
        end
    end

    // Effective capacity: register value limited by the counter range
    assign cap      = ({1'b0, max_frame_bytes} < CountCap) ? max_frame_bytes : CountCap[15:0];
    assign cnt_inc  = cnt_cur + COUNT_BITS'(1);
    assign body_end = {1'b0, flen_cur} + 17'(prlxf_pkg::HEADER_LEN);
    assign flen_new = (32'(cnt_inc) == 32'(prlxf_pkg::HEADER_LEN - 1)) ?
                      {8'h00, rx_byte} : {flen_cur[7:0], rx_byte};
    assign pm_new   = (32'(cnt_cur) < 32'(prlxf_pkg::PREAMBLE_LEN)
                       && rx_byte != prlxf_pkg::sync_byte(cnt_cur[2:0])) ? 1'b0 : pm_cur;

    // Per-byte decode
    always_comb
    begin
        err         = prlxf_pkg::ERR_NONE;
        done        = 1'b0;
        ph_new      = ph_cur;
        count_next  = cnt_cur;
        flen_next   = flen_cur;
        xor_next    = xor_cur;
        pmatch_next = pm_cur;

        if (17'(cnt_cur) + 17'd1 > {1'b0, cap})
        begin
            err = prlxf_pkg::ERR_OVERFLOW;
        end
        else
        begin
            count_next = cnt_inc;
            unique case (ph_cur)
                prlxf_pkg::PH_PREAMBLE:
                begin
                    pmatch_next = pm_new;
                    if (32'(cnt_inc) >= 32'(prlxf_pkg::PREAMBLE_LEN))
                    begin
                        if (!pm_new)
                            err = prlxf_pkg::ERR_PREAMBLE;
                        else
                            ph_new = prlxf_pkg::PH_LENGTH;
                    end
                end
                prlxf_pkg::PH_LENGTH:
                begin
                    xor_next  = xor_cur ^ rx_byte;
                    flen_next = flen_new;
                    if (32'(cnt_inc) != 32'(prlxf_pkg::HEADER_LEN - 1))
                    begin
                        if (flen_new == 16'd0 || flen_new > max_frame_bytes)
                            err = prlxf_pkg::ERR_LENGTH;
                        else
                            ph_new = prlxf_pkg::PH_BODY;
                    end
                end
                default:
                begin
                    // Body; the last byte is the checksum itself
                    if (17'(cnt_inc) >= body_end)
                    begin
                        if (xor_cur != rx_byte)
                            err = prlxf_pkg::ERR_CHECKSUM;
                        else
                        begin
                            ph_new = prlxf_pkg::PH_DONE;
                            done   = 1'b1;
                        end
                    end
                    else
                        xor_next = xor_cur ^ rx_byte;
                end
            endcase
        end

        // Any error clears the frame
        if (err != prlxf_pkg::ERR_NONE)
        begin
            ph_new      = prlxf_pkg::PH_PREAMBLE;
            count_next  = '0;
            flen_next   = '0;
            xor_next    = '0;
            pmatch_next = 1'b1;
        end

        phase_next = ph_new;

        result.data_byte  = rx_byte;
        result.byte_index = 16'(cnt_cur);
        result.rx_phase   = ph_new;
        result.error_code = err;
        result.frame_done = done;

        // Restart clears everything and reports zeros
        if (opcode == prlxf_pkg::OP_RESTART)
        begin
            phase_next  = prlxf_pkg::PH_PREAMBLE;
            count_next  = '0;
            flen_next   = '0;
            xor_next    = '0;
            pmatch_next = 1'b1;
            result      = '0;
        end
    end

    // Frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= prlxf_pkg::PH_PREAMBLE;
            count_reg  <= '0;
            flen_reg   <= '0;
            xor_reg    <= '0;
            pmatch_reg <= 1'b1;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            flen_reg   <= flen_next;
            xor_reg    <= xor_next;
            pmatch_reg <= pmatch_next;
        end
    end

endmodule

### rtl/preamble_length_xor_frame_receiver_unit.sv
// An accepted input beat is registered in the input register and then in the result register.
// Throughput: one byte per cycle unless out_stall holds; each byte decodes in one core pass.
// A stalled result register holds the input register, so up to two beats are in flight.
// Reset (rst_n low, asynchronous): frame state cleared, both stages empty,
// max_frame_bytes returns to 512.
module preamble_length_xor_frame_receiver_unit #(
    parameter int COUNT_BITS = prlxf_pkg::COUNT_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  data_byte,
    output logic [15:0] byte_index,
    output logic [1:0]  rx_phase,
    output logic [2:0]  error_code,
    output logic        frame_done
);

    logic [15:0]        max_frame_reg;
    logic               in_valid_reg;
    logic               op_reg;
    logic [7:0]         byte_reg;
    logic               res_valid_reg;
    prlxf_pkg::result_t res_reg;
    prlxf_pkg::result_t res_next;
    logic               res_free;
    logic               advance;
    logic               accept;

    // Handshake
    assign res_free = !res_valid_reg || !out_stall;
    assign advance  = in_valid_reg && res_free;
    assign in_stall = in_valid_reg && !res_free;
    assign accept   = in_valid && !in_stall;

    // Capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_frame_reg <= prlxf_pkg::MAX_FRAME_RESET;
        else if (cfg_wr_en)
            max_frame_reg <= cfg_wr_data;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (accept)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= opcode;
            byte_reg <= rx_byte;
        end
    end

    prlxf_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .take            (advance),
        .opcode          (op_reg),
        .rx_byte         (byte_reg),
        .max_frame_bytes (max_frame_reg),
        .result          (res_next)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (res_free)
            res_valid_reg <= advance;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign out_valid  = res_valid_reg;
    assign data_byte  = res_reg.data_byte;
    assign byte_index = res_reg.byte_index;
    assign rx_phase   = res_reg.rx_phase;
    assign error_code = res_reg.error_code;
    assign frame_done = res_reg.frame_done;

endmodule

### tb/tb_top.sv
// Self-checking testbench for the preamble/length/XOR frame receiver unit.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Preamble bytes, first byte in the top octet
    localparam logic [39:0] SYNC_SEQ = 40'hAAAAAA9669;
    // Watchdog: far beyond the slowest legal run
    localparam int unsigned RUN_LIMIT_NS = 2_000_000;

    typedef enum int {FR_GOOD, FR_BAD_SYNC, FR_BAD_SUM, FR_CUT} frame_fault_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        in_valid;
    logic        in_stall;
    logic        opcode;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [1:0]  rx_phase;
    logic [2:0]  error_code;
    logic        frame_done;

    // Shadow of the receiver state and the capacity register
    logic [1:0]  rx_ph;
    int unsigned rx_count;
    int unsigned rx_len;
    logic [7:0]  rx_xor;
    logic        sync_ok;
    int unsigned cap_reg;

    prlxf_pkg::result_t expected_q[$];

    int unsigned send_idle_pct;
    int unsigned stall_pct;
    int unsigned hold_left;
    int unsigned fail_cnt;
    int unsigned beats_sent;
    int unsigned results_seen;
    int unsigned frames_seen;
    int unsigned stall_hits;
    int unsigned err_hits [5];

    preamble_length_xor_frame_receiver_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .data_byte   (data_byte),
        .byte_index  (byte_index),
        .rx_phase    (rx_phase),
        .error_code  (error_code),
        .frame_done  (frame_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("status: fail");
        $finish;
    end

    // ---------------------------------------------------------------
    // Frame decode shadow
    // ---------------------------------------------------------------
    function automatic void clear_frame();
        rx_ph    = prlxf_pkg::PH_PREAMBLE;
        rx_count = 0;
        rx_len   = 0;
        rx_xor   = 8'h00;
        sync_ok  = 1'b1;
    endfunction

    function automatic prlxf_pkg::result_t predict_beat(logic op, logic [7:0] b);
        prlxf_pkg::result_t r;
        int unsigned        idx;
        logic [2:0]         err;
        logic               done;
        r    = '0;
        err  = prlxf_pkg::ERR_NONE;
        done = 1'b0;
        if (op == prlxf_pkg::OP_RESTART)
        begin
            clear_frame();
            return r;
        end
        // a byte after a finished frame opens a fresh one
        if (rx_ph == prlxf_pkg::PH_DONE)
            clear_frame();
        idx = rx_count;
        if (rx_count + 1 > cap_reg)
            err = prlxf_pkg::ERR_OVERFLOW;
        else
        begin
            rx_count = rx_count + 1;
            unique case (rx_ph)
                prlxf_pkg::PH_PREAMBLE:
                begin
                    if (idx < 5 && b != SYNC_SEQ[8*(4-idx) +: 8])
                        sync_ok = 1'b0;
                    if (rx_count >= 5)
                    begin
                        if (!sync_ok)
                            err = prlxf_pkg::ERR_PREAMBLE;
                        else
                            rx_ph = prlxf_pkg::PH_LENGTH;
                    end
                end
                prlxf_pkg::PH_LENGTH:
                begin
                    rx_xor = rx_xor ^ b;
                    if (rx_count == 6)
                        rx_len = 32'(b);
                    else
                    begin
                        rx_len = ((rx_len << 8) | 32'(b)) & 32'hFFFF;
                        if (rx_len == 0 || rx_len > cap_reg)
                            err = prlxf_pkg::ERR_LENGTH;
                        else
                            rx_ph = prlxf_pkg::PH_BODY;
                    end
                end
                default:
                begin
                    // last body byte carries the checksum
                    if (rx_count >= rx_len + 7)
                    begin
                        if (rx_xor != b)
                            err = prlxf_pkg::ERR_CHECKSUM;
                        else
                        begin
                            rx_ph = prlxf_pkg::PH_DONE;
                            done  = 1'b1;
                        end
                    end
                    else
                        rx_xor = rx_xor ^ b;
                end
            endcase
        end
        if (err != prlxf_pkg::ERR_NONE)
            clear_frame();
        r.data_byte  = b;
        r.byte_index = idx[15:0];
        r.rx_phase   = rx_ph;
        r.error_code = err;
        r.frame_done = done;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Result side: random stall, long hold-off, field compare
    // ---------------------------------------------------------------
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left = hold_left - 1;
            end
            else
                out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_cnt++;
        end
    endtask

    always @(posedge clk)
    begin : check_result
        prlxf_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (frame_done)
                frames_seen++;
            if (error_code != prlxf_pkg::ERR_NONE && error_code <= prlxf_pkg::ERR_CHECKSUM)
                err_hits[error_code]++;
            if (expected_q.size() == 0)
            begin
                $error("result beat with no expectation pending (data_byte 0x%0h)", data_byte);
                fail_cnt++;
            end
            else
            begin
                want = expected_q.pop_front();
                check_field("data_byte", want.data_byte, data_byte);
                check_field("byte_index", want.byte_index, byte_index);
                check_field("rx_phase", want.rx_phase, rx_phase);
                check_field("error_code", want.error_code, error_code);
                check_field("frame_done", want.frame_done, frame_done);
            end
        end
    end

    // ---------------------------------------------------------------
    // Sender helpers
    // ---------------------------------------------------------------
    task automatic send_beat(logic op, logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
        begin
            stall_hits++;
            @(posedge clk);
        end
        expected_q.push_back(predict_beat(op, b));
        beats_sent++;
    endtask

    // Sends the low n bytes of a vector, most significant first
    task automatic send_hex(logic [71:0] bytes, int n);
        for (int i = n - 1; i >= 0; i--)
            send_beat(prlxf_pkg::OP_BYTE, bytes[8*i +: 8]);
    endtask

    // Builds and sends one frame; faults corrupt it in the chosen way
    task automatic send_frame(logic [15:0] len, frame_fault_t fault);
        logic [39:0] sync;
        logic [7:0]  sum;
        logic [7:0]  b;
        int unsigned bad_pos;
        int unsigned body_n;
        sync = SYNC_SEQ;
        if (fault == FR_BAD_SYNC)
        begin
            bad_pos = $urandom_range(4);
            sync[8*(4-bad_pos) +: 8] = sync[8*(4-bad_pos) +: 8] ^ 8'($urandom_range(1, 255));
        end
        for (int i = 4; i >= 0; i--)
            send_beat(prlxf_pkg::OP_BYTE, sync[8*i +: 8]);
        if (fault == FR_BAD_SYNC)
            return;
        send_beat(prlxf_pkg::OP_BYTE, len[15:8]);
        send_beat(prlxf_pkg::OP_BYTE, len[7:0]);
        // header rejected: nothing more belongs to this frame
        if (len == 0 || 32'(len) > cap_reg)
            return;
        sum    = len[15:8] ^ len[7:0];
        body_n = 32'(len) - 1;
        if (fault == FR_CUT)
            body_n = $urandom_range(0, (body_n < 8) ? body_n : 8);
        for (int unsigned i = 0; i < body_n; i++)
        begin
            b   = 8'($urandom);
            sum = sum ^ b;
            send_beat(prlxf_pkg::OP_BYTE, b);
        end
        if (fault == FR_CUT)
            send_beat(prlxf_pkg::OP_RESTART, 8'($urandom));
        else if (fault == FR_BAD_SUM)
            send_beat(prlxf_pkg::OP_BYTE, sum ^ 8'($urandom_range(1, 255)));
        else
            send_beat(prlxf_pkg::OP_BYTE, sum);
    endtask

    // Waits until every result is back, then lets the pipeline settle
    task automatic drain_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_capacity(logic [15:0] value);
        drain_block();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        cap_reg = 32'(value);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_directed_frames();
        send_idle_pct = 27;
        stall_pct     = 27;
        // good frame with a two-byte body
        send_hex(72'hAAAAAA9669_0002FF_FD, 9);
        // byte after a good frame opens a new one, broken preamble
        send_hex(72'hAAAAAA9600, 5);
        // zero length field
        send_hex(72'hAAAAAA9669_0000, 7);
        // restart in the middle of a preamble
        send_hex(72'hAAAA, 2);
        send_beat(prlxf_pkg::OP_RESTART, 8'hFF);
        // wrong checksum on a one-byte body
        send_hex(72'hAAAAAA9669_0001_55, 8);
    endtask

    task automatic test_capacity_limits();
        write_capacity(16'd10);
        send_frame(16'd3, FR_GOOD);      // fills capacity exactly
        send_frame(16'd4, FR_GOOD);      // overflows on the checksum byte
        send_frame(16'd11, FR_GOOD);     // length above capacity
        write_capacity(16'hFFFF);
        send_frame(16'hFFFF, FR_CUT);
        send_frame(16'h8000, FR_CUT);
        write_capacity(prlxf_pkg::MAX_FRAME_RESET);
        send_frame(16'd513, FR_GOOD);
        send_frame(16'd512, FR_CUT);
    endtask

    task automatic test_random_traffic(int unsigned idle, int unsigned stall,
                                       logic [15:0] cap, int unsigned n_beats);
        int unsigned target;
        int unsigned pick;
        int unsigned len_top;
        int unsigned len;
        write_capacity(cap);
        send_idle_pct = idle;
        stall_pct     = stall;
        target = beats_sent + n_beats;
        len_top = (cap_reg >= 19) ? 12 : cap_reg - 7;
        while (beats_sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 62)
            begin
                len = $urandom_range(1, len_top);
                if ($urandom_range(19) == 0 && cap_reg >= 47)
                    len = $urandom_range(13, 40);
                send_frame(16'(len), FR_GOOD);
            end
            else if (pick < 70)
                send_frame(16'($urandom_range(1, len_top)), FR_BAD_SYNC);
            else if (pick < 78)
                send_frame(16'($urandom_range(1, len_top)), FR_BAD_SUM);
            else if (pick < 84)
                send_frame(16'($urandom_range(1, len_top + 4)), FR_CUT);
            else if (pick < 89)
            begin
                // zero length, or a length just above capacity or at 0xFFFF
                if (cap_reg == 32'hFFFF || $urandom_range(1) == 0)
                    send_frame(16'd0, FR_GOOD);
                else
                    send_frame(($urandom_range(1) == 0) ? 16'(cap_reg + 1) : 16'hFFFF, FR_GOOD);
            end
            else if (pick < 94 && cap_reg < 60)
                // header passes but the whole frame does not fit
                send_frame(16'($urandom_range(cap_reg - 6, cap_reg)), FR_GOOD);
            else
            begin
                // line noise with the odd restart
                repeat ($urandom_range(1, 6))
                    send_beat(($urandom_range(9) == 0) ? prlxf_pkg::OP_RESTART
                                                       : prlxf_pkg::OP_BYTE,
                              ($urandom_range(3) == 0) ? 8'hAA : 8'($urandom));
            end
        end
    endtask

    task automatic test_backpressure();
        drain_block();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_left     = 200;
        send_frame(16'd24, FR_GOOD);
        send_frame(16'd5, FR_BAD_SUM);
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 16'h0000;
        in_valid      = 1'b0;
        opcode        = prlxf_pkg::OP_BYTE;
        rx_byte       = 8'h00;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_left     = 0;
        fail_cnt      = 0;
        beats_sent    = 0;
        results_seen  = 0;
        frames_seen   = 0;
        stall_hits    = 0;
        foreach (err_hits[i])
            err_hits[i] = 0;
        cap_reg = 32'(prlxf_pkg::MAX_FRAME_RESET);
        clear_frame();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_frames();
        test_capacity_limits();
        test_random_traffic(0, 0, prlxf_pkg::MAX_FRAME_RESET, 120);
        test_random_traffic(52, 0, 16'hFFFF, 120);
        test_random_traffic(0, 52, 16'd10, 120);
        test_random_traffic(27, 27, 16'($urandom_range(10, 64)), 120);
        test_backpressure();

        drain_block();
        repeat (10) @(posedge clk);

        $display("Sent %0d beats, checked %0d results; %0d complete frames, %0d stalled cycles",
                 beats_sent, results_seen, frames_seen, stall_hits);
        $display("Errors seen: overflow %0d, preamble %0d, length %0d, checksum %0d",
                 err_hits[prlxf_pkg::ERR_OVERFLOW], err_hits[prlxf_pkg::ERR_PREAMBLE],
                 err_hits[prlxf_pkg::ERR_LENGTH], err_hits[prlxf_pkg::ERR_CHECKSUM]);
        if (fail_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
